[src/rslr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rslr_pkg;

  localparam int MAX_PAYLOAD_DEF = 100;

  localparam logic [7:0] PREAMBLE = 8'hAA;
  localparam int DIV_W = 16;
  localparam int DSR_W = 8;

  // configuration register indexes
  localparam logic [2:0] REG_ID_PRODUCT_NAME  = 3'd0;
  localparam logic [2:0] REG_ID_UPDATE_RATE   = 3'd1;
  localparam logic [2:0] REG_ID_OUTPUT_FIELDS = 3'd2;
  localparam logic [2:0] REG_ID_STREAM        = 3'd3;
  localparam logic [2:0] REG_ID_DISTANCE_DATA = 3'd4;

  typedef enum logic [1:0] {
    KIND_NAME,
    KIND_ACK,
    KIND_DIST
  } kind_t;

  // one queued reply frame
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [31:0] value;
    logic        in_range;
    logic [9:0]  period;
    logic        stream;
  } entry_t;

  // front to queue
  typedef struct packed {
    logic   push;
    entry_t data;
  } push_t;

  // queue to back
  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t data;
  } qstat_t;

  // crc-16/xmodem, one byte
  function automatic logic [15:0] crc_upd(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_PRE = crc_upd(16'h0000, PREAMBLE);

  // product name text
  function automatic logic [7:0] name_char(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h47;
      3'd1: r = 8'h52;
      3'd2: r = 8'h46;
      3'd3: r = 8'h32;
      3'd4: r = 8'h35;
      3'd5: r = 8'h30;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[src/rslr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rslr_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [7:0]         rx_byte;
  logic signed [23:0] sample_cm;
  modport source (output valid, opcode, rx_byte, sample_cm, input ready);
  modport sink (input valid, opcode, rx_byte, sample_cm, output ready);
endinterface
`default_nettype wire

[src/rslr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rslr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;
  logic [9:0] period_ms;
  logic       streaming;
  modport source (output valid, tx_byte, frame_end, period_ms, streaming, input ready);
  modport sink (input valid, tx_byte, frame_end, period_ms, streaming, output ready);
endinterface
`default_nettype wire

[src/rslr_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rslr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/rslr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rslr_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rslr_pkg::DIV_W-1:0]  dividend,
  input  wire logic [rslr_pkg::DSR_W-1:0]  divisor,
  output logic                             done,
  output logic [rslr_pkg::DIV_W-1:0]       quotient
);
  import rslr_pkg::*;

  logic             busy;
  logic [3:0]       cnt;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W-1:0] rem;
  logic [DSR_W:0]   rs;
  logic             ge;

  // one restoring step per cycle
  always_comb begin
    rs = {rem, quotient[DIV_W-1]};
    ge = rs >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
      end else if (busy) begin
        rem      <= ge ? DSR_W'(rs - {1'b0, dsr}) : rs[DSR_W-1:0];
        quotient <= {quotient[DIV_W-2:0], ge};
        cnt      <= cnt + 4'd1;
        if (cnt == 4'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without work");
`endif
endmodule
`default_nettype wire

[src/rslr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module rslr_front #(
  parameter int MaxPayload = rslr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  rslr_in_if.sink       rx,
  rslr_cfg_if.sink      cfg,
  input  wire logic     q_full,
  output rslr_pkg::push_t push
);
  import rslr_pkg::*;

  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_FLO  = 7'b0000010,
    PH_FHI  = 7'b0000100,
    PH_ID   = 7'b0001000,
    PH_PAY  = 7'b0010000,
    PH_CLO  = 7'b0100000,
    PH_CHI  = 7'b1000000
  } phase_t;

  phase_t      phase;
  logic [15:0] flags;
  logic [7:0]  plen;
  logic [7:0]  bcnt;
  logic [7:0]  fid;
  logic [31:0] fpw;
  logic [15:0] crc_run;
  logic [7:0]  crc_lo;
  logic        stream_on;
  logic [9:0]  period;
  logic [7:0]  id_name, id_rate, id_out, id_str, id_dist;

  // pending rate division
  logic        pend;
  logic [7:0]  pend_rate;

  logic        acc, is_byte, good;
  logic        hit_name, hit_rate, hit_out, hit_str, fpw_five;
  logic        sample_go;
  logic [7:0]  b;
  logic [15:0] crc_b;
  logic [15:0] fh;
  logic [7:0]  plen_c;
  logic [7:0]  rate;
  logic        lt, gt;
  logic [15:0] cm16;
  logic [31:0] cm_prod;
  logic        div_start, div_done;
  logic [15:0] div_a, div_q;
  logic [7:0]  div_d;

  assign rx.ready  = !pend && !q_full;
  assign cfg.ready = 1'b1;
  assign acc       = rx.valid && rx.ready;
  assign is_byte   = !rx.opcode;
  assign b         = rx.rx_byte;
  assign crc_b     = crc_upd(crc_run, b);
  assign fh        = {b, flags[7:0]};
  assign plen_c    = fh[13:6] - 8'd1;

  // frame decode at the second crc byte
  assign good      = acc && is_byte && (phase == PH_CHI) && ({b, crc_lo} == crc_run);
  assign hit_name  = fid == id_name;
  assign hit_rate  = !hit_name && fid == id_rate;
  assign hit_out   = !hit_name && !hit_rate && fid == id_out;
  assign hit_str   = !hit_name && !hit_rate && !hit_out && fid == id_str;
  assign fpw_five  = fpw == 32'd5;
  assign rate      = (fpw[7:0] == 8'd0) ? 8'd1 : fpw[7:0];
  assign sample_go = acc && !is_byte && stream_on;

  // distance clamp, then divide by ten through a reciprocal multiply
  assign lt      = rx.sample_cm < 24'sd20;
  assign gt      = rx.sample_cm > 24'sd50000;
  assign cm16    = lt ? 16'd20 : (gt ? 16'd50000 : rx.sample_cm[15:0]);
  assign cm_prod = {16'h0000, cm16} * 32'd52429;

  assign div_start = good && hit_rate;
  assign div_a     = 16'd1000;
  assign div_d     = rate;

  rslr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // reply request to the queue
  always_comb begin
    push.push          = 1'b0;
    push.data.kind     = KIND_ACK;
    push.data.id       = id_out;
    push.data.value    = fpw;
    push.data.in_range = 1'b0;
    push.data.period   = period;
    push.data.stream   = stream_on;
    if (div_done) begin
      push.push        = 1'b1;
      push.data.id     = id_rate;
      push.data.value  = {24'h000000, pend_rate};
      push.data.period = div_q[9:0];
    end else if (sample_go) begin
      push.push          = 1'b1;
      push.data.kind     = KIND_DIST;
      push.data.id       = id_dist;
      push.data.value    = {19'h00000, cm_prod[31:19]};
      push.data.in_range = !(lt || gt);
    end else if (good) begin
      if (hit_name) begin
        push.push      = 1'b1;
        push.data.kind = KIND_NAME;
        push.data.id   = id_name;
      end else if (hit_out) begin
        push.push = 1'b1;
      end else if (hit_str && fpw_five) begin
        push.push        = 1'b1;
        push.data.id     = id_str;
        push.data.stream = 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      id_name <= 8'd0;
      id_rate <= 8'd74;
      id_out  <= 8'd27;
      id_str  <= 8'd30;
      id_dist <= 8'd44;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_ID_PRODUCT_NAME:  id_name <= cfg.data;
        REG_ID_UPDATE_RATE:   id_rate <= cfg.data;
        REG_ID_OUTPUT_FIELDS: id_out  <= cfg.data;
        REG_ID_STREAM:        id_str  <= cfg.data;
        REG_ID_DISTANCE_DATA: id_dist <= cfg.data;
        default: ;
      endcase
    end
  end

  // frame parser and command state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      flags     <= '0;
      plen      <= '0;
      bcnt      <= '0;
      fid       <= '0;
      fpw       <= '0;
      crc_run   <= '0;
      crc_lo    <= '0;
      stream_on <= 1'b0;
      period    <= 10'd100;
      pend      <= 1'b0;
    end else begin
      if (div_done) begin
        pend   <= 1'b0;
        period <= div_q[9:0];
      end
      if (acc && is_byte) begin
        unique case (phase)
          PH_FLO: begin
            flags   <= {8'h00, b};
            crc_run <= crc_b;
            phase   <= PH_FHI;
          end
          PH_FHI: begin
            if (plen_c > 8'(MaxPayload)) begin
              // rescan the two flag bytes for a preamble
              if (flags[7:0] == PREAMBLE) begin
                crc_run <= crc_upd(CRC_PRE, b);
                flags   <= {8'h00, b};
                phase   <= PH_FHI;
              end else if (b == PREAMBLE) begin
                crc_run <= CRC_PRE;
                phase   <= PH_FLO;
              end else begin
                phase <= PH_HUNT;
              end
            end else begin
              flags   <= fh;
              plen    <= plen_c;
              crc_run <= crc_b;
              phase   <= PH_ID;
            end
          end
          PH_ID: begin
            fid     <= b;
            crc_run <= crc_b;
            bcnt    <= '0;
            fpw     <= '0;
            phase   <= (plen != 8'd0) ? PH_PAY : PH_CLO;
          end
          PH_PAY: begin
            if (bcnt < 8'd4) fpw <= fpw | ({24'h000000, b} << {bcnt[1:0], 3'b000});
            crc_run <= crc_b;
            bcnt    <= bcnt + 8'd1;
            if (bcnt + 8'd1 >= plen) phase <= PH_CLO;
          end
          PH_CLO: begin
            crc_lo <= b;
            phase  <= PH_CHI;
          end
          PH_CHI: begin
            phase <= PH_HUNT;
            if (good) begin
              if (hit_rate) begin
                pend      <= 1'b1;
                pend_rate <= rate;
              end else if (hit_str) begin
                stream_on <= fpw_five;
              end
            end
          end
          default: begin
            if (b == PREAMBLE) begin
              crc_run <= CRC_PRE;
              phase   <= PH_FLO;
            end else begin
              phase <= PH_HUNT;
            end
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push.push |-> !q_full)
    else $error("push into full queue");
`endif
endmodule
`default_nettype wire

[src/rslr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module rslr_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rslr_pkg::push_t push,
  input  wire logic        pop,
  output rslr_pkg::qstat_t stat
);
  import rslr_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign stat.empty = count == 2'd0;
  assign stat.full  = count == 2'd2;
  assign stat.data  = mem[rd_ptr];

  // two-entry request queue
  always_ff @(posedge clk) begin
    if (push.push) mem[wr_ptr] <= push.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push.push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push.push) - 2'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

[src/rslr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module rslr_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rslr_pkg::qstat_t stat,
  output logic             pop,
  rslr_out_if.source       tx
);
  import rslr_pkg::*;

  logic        busy;
  entry_t      cur;
  logic [3:0]  cnt;
  logic [15:0] crc;
  logic [3:0]  dlen;
  logic [7:0]  dbyte;
  logic [7:0]  obyte;
  logic        fire;

  assign pop  = !busy && !stat.empty;
  assign fire = tx.valid && tx.ready;

  // data byte of the current frame
  always_comb begin
    dlen  = 4'd8;
    dbyte = 8'h00;
    unique case (cur.kind)
      KIND_NAME: begin
        dlen = 4'd11;
        unique case (cnt)
          4'd0: dbyte = PREAMBLE;
          4'd1: dbyte = 8'h01;
          4'd2: dbyte = 8'h02;
          4'd3: dbyte = cur.id;
          default: dbyte = name_char(3'(cnt - 4'd4));
        endcase
      end
      KIND_ACK, KIND_DIST: begin
        dlen = (cur.kind == KIND_DIST) ? 4'd12 : 4'd8;
        unique case (cnt)
          4'd0: dbyte = PREAMBLE;
          4'd1: dbyte = 8'h41;
          4'd2: dbyte = (cur.kind == KIND_DIST) ? 8'h02 : 8'h01;
          4'd3: dbyte = cur.id;
          4'd4: dbyte = cur.value[7:0];
          4'd5: dbyte = cur.value[15:8];
          4'd6: dbyte = cur.value[23:16];
          4'd7: dbyte = cur.value[31:24];
          4'd8: dbyte = cur.in_range ? 8'd100 : 8'd0;
          default: dbyte = 8'h00;
        endcase
      end
      default: ;
    endcase
    if (cnt == dlen) obyte = crc[7:0];
    else if (cnt == dlen + 4'd1) obyte = crc[15:8];
    else obyte = dbyte;
  end

  assign tx.valid     = busy;
  assign tx.tx_byte   = obyte;
  assign tx.frame_end = cnt == dlen + 4'd1;
  assign tx.period_ms = cur.period;
  assign tx.streaming = cur.stream;

  // frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      crc  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cur  <= stat.data;
      cnt  <= '0;
      crc  <= '0;
    end else if (fire) begin
      if (cnt < dlen) crc <= crc_upd(crc, dbyte);
      cnt <= cnt + 4'd1;
      if (tx.frame_end) busy <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= dlen + 4'd1)
    else $error("frame byte index past end");
  a_end_done: assert property (@(posedge clk) disable iff (rst)
      (fire && tx.frame_end) |=> !busy)
    else $error("sequencer busy after frame end");
`endif
endmodule
`default_nettype wire

[src/rangefinder_serial_link_responder.sv]
// a byte that completes a frame, or a distance sample, is written into the queue; the sequencer then pops it
// and registers it before its first reply byte; a rate command first passes through the 16-step divider
// throughput: 1 request per cycle while the 2-entry queue has room and no rate division is pending
// replies leave at 1 byte per cycle while tx.ready is high; the sequencer idles between frames to pop the next entry
// reset: synchronous, clears parser, queue and sequencer; period 100, streaming off
`timescale 1ns / 1ps
`default_nettype none
module rangefinder_serial_link_responder #(
  parameter int MaxPayload = rslr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rslr_in_if.sink     rx,
  rslr_out_if.source  tx,
  rslr_cfg_if.sink    cfg
);
  import rslr_pkg::*;

  push_t  push;
  qstat_t stat;
  logic   pop;

  rslr_front #(.MaxPayload(MaxPayload)) u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .cfg    (cfg),
    .q_full (stat.full),
    .push   (push)
  );

  rslr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (stat)
  );

  rslr_back u_back (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .pop  (pop),
    .tx   (tx)
  );
endmodule
`default_nettype wire
